### hdl/dwos_pkg.sv
// ----------------------------------------------------------------------------
// dwos_pkg
// Types and constants for the dual wheel odometry and speed block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwos_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_MM_PER_COUNT        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SIGN_NEGATIVE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SIGN_NEGATIVE = 2'd2;

    localparam logic [19:0] DT_MIN_US = 20'd100;

    // radix-4 restoring divide of a 60-bit dividend
    localparam int DIVIDEND_W = 60;
    localparam int DIV_STEPS  = DIVIDEND_W / 2;

    localparam logic signed [47:0] SPEED_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SPEED_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [15:0] left_raw;
        logic [15:0] right_raw;
        logic [19:0] dt_us;
    } dwos_in_t;

    typedef struct packed {
        logic signed [15:0] left_step;
        logic signed [15:0] right_step;
        logic signed [31:0] left_total;
        logic signed [31:0] right_total;
        logic signed [47:0] left_distance;
        logic signed [47:0] right_distance;
        logic signed [47:0] left_speed;
        logic signed [47:0] right_speed;
    } dwos_out_t;

endpackage

`default_nettype wire

### hdl/dual_wheel_odometry_speed_top.sv
// ----------------------------------------------------------------------------
// dual_wheel_odometry_speed_top
// Encoder deltas, wrapping totals, distances and filtered wheel speeds,
// computed by one shared multiplier and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                     direction  word
//  s_        s_valid s_ready s_data    in         dwos_in_t
//  m_        m_valid m_ready m_data    out        dwos_out_t
//  cfg_      cfg_wr_en cfg_index ...   in         24-bit register write
//
//  per word: two distance multiplies, then, when dt_us > 100, per wheel one
//  multiply, two scale adds, 30 divider steps (2 quotient bits each),
//  saturate and filter, then the output load.
//  s_ready is high only while the sequencer is idle.
//  the output register holds a finished word while the next one is taken in;
//  the sequencer waits at its last step until that register is free.
//  aresetn clears configuration, samples, totals and speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_odometry_speed_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire dwos_pkg::dwos_in_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output dwos_pkg::dwos_out_t                m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dwos_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dwos_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dwos_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIST = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_K1   = 4'd3;
    localparam logic [3:0] ST_K2   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_SAT  = 4'd6;
    localparam logic [3:0] ST_FILT = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic        wheel_reg, wheel_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [23:0] mm_reg, mm_next;
    logic        lneg_reg, lneg_next;
    logic        rneg_reg, rneg_next;

    logic [15:0] prev_l_reg, prev_l_next;
    logic [15:0] prev_r_reg, prev_r_next;
    logic [31:0] total_l_reg, total_l_next;
    logic [31:0] total_r_reg, total_r_next;
    logic signed [47:0] speed_l_reg, speed_l_next;
    logic signed [47:0] speed_r_reg, speed_r_next;

    logic [15:0] delta_l_reg, delta_l_next;
    logic [15:0] delta_r_reg, delta_r_next;
    logic [19:0] dt_reg, dt_next;
    logic        upd_reg, upd_next;
    logic [47:0] dist_l_reg, dist_l_next;
    logic [47:0] dist_r_reg, dist_r_next;
    logic [39:0] x_reg, x_next;
    logic [DIVIDEND_W-1:0] acc_reg, acc_next;
    logic [19:0] rem_reg, rem_next;
    logic signed [47:0] raw_reg, raw_next;

    logic        m_valid_reg, m_valid_next;
    dwos_out_t   m_data_reg, m_data_next;

    logic [15:0] in_dl_raw, in_dr_raw, in_dl, in_dr;
    logic [15:0] cur_delta, cur_mag;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] prod;
    logic [59:0] x_wide;
    logic [20:0] step_hi, step_lo;
    logic signed [47:0] cur_speed;
    logic signed [48:0] diff;
    logic signed [48:0] diff_sh;
    logic signed [47:0] speed_new;
    logic        out_free;

    function automatic logic [20:0] div_step(input logic [19:0] r, input logic b,
                                             input logic [19:0] d);
        logic [20:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            div_step = {1'b1, 20'(t - {1'b0, d})};
        end else begin
            div_step = {1'b0, t[19:0]};
        end
    endfunction

    assign in_dl_raw = s_data.left_raw - prev_l_reg;
    assign in_dr_raw = s_data.right_raw - prev_r_reg;
    assign in_dl     = lneg_reg ? 16'(16'd0 - in_dl_raw) : in_dl_raw;
    assign in_dr     = rneg_reg ? 16'(16'd0 - in_dr_raw) : in_dr_raw;

    assign cur_delta = wheel_reg ? delta_r_reg : delta_l_reg;
    assign cur_mag   = cur_delta[15] ? 16'(16'd0 - cur_delta) : cur_delta;
    assign cur_speed = wheel_reg ? speed_r_reg : speed_l_reg;

    // shared multiplier: signed total for distance, delta magnitude for speed
    always_comb begin
        if (state_reg == ST_DIST) begin
            mul_a = wheel_reg ? $signed({total_r_reg[31], total_r_reg})
                              : $signed({total_l_reg[31], total_l_reg});
        end else begin
            mul_a = $signed({17'd0, cur_mag});
        end
    end
    assign mul_b = $signed({1'b0, mm_reg});
    assign prod  = mul_a * mul_b;

    assign x_wide  = {20'd0, x_reg};
    assign step_hi = div_step(rem_reg, acc_reg[DIVIDEND_W-1], dt_reg);
    assign step_lo = div_step(step_hi[19:0], acc_reg[DIVIDEND_W-2], dt_reg);

    assign diff      = $signed({raw_reg[47], raw_reg}) - $signed({cur_speed[47], cur_speed});
    assign diff_sh   = diff >>> 2;
    assign speed_new = cur_speed + diff_sh[47:0];

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        wheel_next   = wheel_reg;
        cnt_next     = cnt_reg;
        mm_next      = mm_reg;
        lneg_next    = lneg_reg;
        rneg_next    = rneg_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        total_l_next = total_l_reg;
        total_r_next = total_r_reg;
        speed_l_next = speed_l_reg;
        speed_r_next = speed_r_reg;
        delta_l_next = delta_l_reg;
        delta_r_next = delta_r_reg;
        dt_next      = dt_reg;
        upd_next     = upd_reg;
        dist_l_next  = dist_l_reg;
        dist_r_next  = dist_r_reg;
        x_next       = x_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        raw_next     = raw_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MM_PER_COUNT:        mm_next   = cfg_wdata;
                REG_LEFT_SIGN_NEGATIVE:  lneg_next = cfg_wdata[0];
                REG_RIGHT_SIGN_NEGATIVE: rneg_next = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    prev_l_next  = s_data.left_raw;
                    prev_r_next  = s_data.right_raw;
                    delta_l_next = in_dl;
                    delta_r_next = in_dr;
                    total_l_next = total_l_reg + {{16{in_dl[15]}}, in_dl};
                    total_r_next = total_r_reg + {{16{in_dr[15]}}, in_dr};
                    dt_next      = s_data.dt_us;
                    upd_next     = s_data.dt_us > DT_MIN_US;
                    wheel_next   = 1'b0;
                    state_next   = ST_DIST;
                end
            end
            ST_DIST: begin
                if (!wheel_reg) begin
                    dist_l_next = prod[55:8];
                    wheel_next  = 1'b1;
                end else begin
                    dist_r_next = prod[55:8];
                    wheel_next  = 1'b0;
                    state_next  = upd_reg ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                x_next     = prod[39:0];
                state_next = ST_K1;
            end
            ST_K1: begin
                // times 1000000 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6
                acc_next   = (x_wide << 20) - (x_wide << 16);
                state_next = ST_K2;
            end
            ST_K2: begin
                acc_next   = acc_reg + (x_wide << 14) + (x_wide << 9) + (x_wide << 6);
                rem_next   = 20'd0;
                cnt_next   = 5'd0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = step_lo[19:0];
                acc_next = {acc_reg[DIVIDEND_W-3:0], step_hi[20], step_lo[20]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if (cur_delta[15]) begin
                    if (acc_reg > {12'd0, 1'b1, 47'd0}) begin
                        raw_next = SPEED_MIN;
                    end else begin
                        raw_next = $signed(48'(48'd0 - acc_reg[47:0]));
                    end
                end else begin
                    if (acc_reg[DIVIDEND_W-1:47] != '0) begin
                        raw_next = SPEED_MAX;
                    end else begin
                        raw_next = $signed(acc_reg[47:0]);
                    end
                end
                state_next = ST_FILT;
            end
            ST_FILT: begin
                if (!wheel_reg) begin
                    speed_l_next = speed_new;
                    wheel_next   = 1'b1;
                    state_next   = ST_MUL;
                end else begin
                    speed_r_next = speed_new;
                    wheel_next   = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next.left_step      = $signed(delta_l_reg);
                    m_data_next.right_step     = $signed(delta_r_reg);
                    m_data_next.left_total     = $signed(total_l_reg);
                    m_data_next.right_total    = $signed(total_r_reg);
                    m_data_next.left_distance  = $signed(dist_l_reg);
                    m_data_next.right_distance = $signed(dist_r_reg);
                    m_data_next.left_speed     = speed_l_reg;
                    m_data_next.right_speed    = speed_r_reg;
                    m_valid_next               = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wheel_reg   <= 1'b0;
            cnt_reg     <= 5'd0;
            mm_reg      <= 24'd0;
            lneg_reg    <= 1'b0;
            rneg_reg    <= 1'b0;
            prev_l_reg  <= 16'd0;
            prev_r_reg  <= 16'd0;
            total_l_reg <= 32'd0;
            total_r_reg <= 32'd0;
            speed_l_reg <= 48'sd0;
            speed_r_reg <= 48'sd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wheel_reg   <= wheel_next;
            cnt_reg     <= cnt_next;
            mm_reg      <= mm_next;
            lneg_reg    <= lneg_next;
            rneg_reg    <= rneg_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            total_l_reg <= total_l_next;
            total_r_reg <= total_r_next;
            speed_l_reg <= speed_l_next;
            speed_r_reg <= speed_r_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_l_reg <= delta_l_next;
        delta_r_reg <= delta_r_next;
        dt_reg      <= dt_next;
        upd_reg     <= upd_next;
        dist_l_reg  <= dist_l_next;
        dist_r_reg  <= dist_r_next;
        x_reg       <= x_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        raw_reg     <= raw_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
